// ----- sv/crcp_pkg.sv -----
package crcp_pkg;

  // fixed field widths
  localparam int ADDR_W  = 48;
  localparam int DIM_W   = 13;
  localparam int PITCH_W = 14;
  localparam int STRD_W  = 18;
  localparam int CRD_W   = 20;
  localparam int COL_W   = 32;
  localparam int QDEPTH  = 4;

  // command modes
  typedef enum logic [2:0] {
    MODE_PIXEL  = 3'd0,
    MODE_HLINE  = 3'd1,
    MODE_VLINE  = 3'd2,
    MODE_RECT   = 3'd3,
    MODE_SCROLL = 3'd4,
    MODE_BLIT   = 3'd5
  } mode_t;

  // descriptor action codes
  typedef enum logic [1:0] {
    ACT_FILL      = 2'd0,
    ACT_COPY_FILL = 2'd1,
    ACT_COPY      = 2'd2
  } action_t;

  // register indexes
  typedef enum logic [2:0] {
    REG_FB_BASE       = 3'd0,
    REG_SCREEN_WIDTH  = 3'd1,
    REG_SCREEN_HEIGHT = 3'd2,
    REG_ROW_PITCH     = 3'd3,
    REG_READY_CFG     = 3'd4
  } reg_idx_t;

  // what the back end has to do with a classified command
  typedef enum logic [1:0] {
    KIND_FILL   = 2'd0,
    KIND_SCROLL = 2'd1,
    KIND_BLIT   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  fb_base;
    logic [DIM_W-1:0]   screen_width;
    logic [DIM_W-1:0]   screen_height;
    logic [PITCH_W-1:0] row_pitch;
    logic               ready_cfg;
  } cfg_t;

  // classified and clipped command, one queue entry
  typedef struct packed {
    logic              reject;
    kind_t             kind;
    logic [DIM_W-1:0]  x0;
    logic [DIM_W-1:0]  y0;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  rows;
    logic [15:0]       dy;
    logic [COL_W-1:0]  color;
    logic [ADDR_W-1:0] sbase;
    logic [STRD_W-1:0] sstride;
    logic [15:0]       ox;
    logic [15:0]       oy;
  } cmd_t;

  // result descriptor
  typedef struct packed {
    logic              status;
    action_t           action;
    logic [ADDR_W-1:0] dst_addr;
    logic [ADDR_W-1:0] src_addr;
    logic [STRD_W-1:0] src_pitch_bytes;
    logic [DIM_W-1:0]  row_pixels;
    logic [DIM_W-1:0]  copy_rows;
    logic [ADDR_W-1:0] fill_addr;
    logic [DIM_W-1:0]  fill_rows;
    logic [COL_W-1:0]  fill_pixel;
  } desc_t;

endpackage

// ----- sv/clipped_raster_command_planner.sv -----
// Clipped raster command planner.
// Command channel: cmd_valid/cmd_stall with one field per port (mode, origin,
// sizes, shift, colour, blit source). A beat is taken at a rising edge with
// cmd_valid high and cmd_stall low. Each command is clipped against the
// programmed screen and turned into one descriptor beat on the desc_valid /
// desc_stall channel for a downstream fill/copy engine.
// A taken command is written into the queue, then into stages a and b and the
// descriptor register. One command per cycle while desc_stall is low, set by
// the three-stage address pipeline (row index, row offset multiply, add).
// A four-entry queue sits between the classifier and the address pipeline.
// When desc_stall is high the pipeline holds its descriptor, the queue fills,
// and cmd_stall rises once all four entries are taken.
// Registers are written over the APB port at byte address 8*index; the user
// must write them only while no command is in flight, the block does not
// enforce this. Reset empties the queue and pipeline and clears all registers,
// so every command is rejected (status 1) until fb_base and ready_cfg are set.
module clipped_raster_command_planner #(
  parameter int ADDR_BITS = 48,
  parameter int MAX_DIM   = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [5:0]                    paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready,
  // command channel
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  logic [2:0]                    mode,
  input  logic signed [15:0]            pos_x,
  input  logic signed [15:0]            pos_y,
  input  logic signed [15:0]            size_x,
  input  logic signed [15:0]            size_y,
  input  logic signed [15:0]            shift_rows,
  input  logic [31:0]                   color,
  input  logic [47:0]                   image_base,
  input  logic [17:0]                   src_stride,
  // descriptor channel
  output logic                          desc_valid,
  input  logic                          desc_stall,
  output logic                          status,
  output logic [1:0]                    action,
  output logic [47:0]                   dst_addr,
  output logic [47:0]                   src_addr,
  output logic [17:0]                   src_pitch_bytes,
  output logic [12:0]                   row_pixels,
  output logic [12:0]                   copy_rows,
  output logic [47:0]                   fill_addr,
  output logic [12:0]                   fill_rows,
  output logic [31:0]                   fill_pixel
);

  crcp_pkg::cfg_t     cfg;
  crcp_pkg::reg_idx_t reg_idx;
  crcp_pkg::cmd_t     front_cmd;
  crcp_pkg::cmd_t     q_cmd;
  crcp_pkg::desc_t    desc;
  logic               q_full;
  logic               q_nonempty;
  logic               q_pop;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = crcp_pkg::reg_idx_t'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        crcp_pkg::REG_FB_BASE:       cfg.fb_base       <= pwdata[47:0];
        crcp_pkg::REG_SCREEN_WIDTH:  cfg.screen_width  <= pwdata[12:0];
        crcp_pkg::REG_SCREEN_HEIGHT: cfg.screen_height <= pwdata[12:0];
        crcp_pkg::REG_ROW_PITCH:     cfg.row_pitch     <= pwdata[13:0];
        crcp_pkg::REG_READY_CFG:     cfg.ready_cfg     <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      crcp_pkg::REG_FB_BASE:       prdata = 64'(cfg.fb_base);
      crcp_pkg::REG_SCREEN_WIDTH:  prdata = 64'(cfg.screen_width);
      crcp_pkg::REG_SCREEN_HEIGHT: prdata = 64'(cfg.screen_height);
      crcp_pkg::REG_ROW_PITCH:     prdata = 64'(cfg.row_pitch);
      crcp_pkg::REG_READY_CFG:     prdata = 64'(cfg.ready_cfg);
      default:                     prdata = '0;
    endcase
  end

  // classify and clip
  crcp_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .cfg        (cfg),
    .mode       (mode),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .size_x     (size_x),
    .size_y     (size_y),
    .shift_rows (shift_rows),
    .color      (color),
    .image_base (image_base),
    .src_stride (src_stride),
    .cmd        (front_cmd)
  );

  assign cmd_stall = q_full;

  // decoupling queue
  crcp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_valid),
    .wdata    (front_cmd),
    .full     (q_full),
    .nonempty (q_nonempty),
    .rdata    (q_cmd),
    .pop      (q_pop)
  );

  // address pipeline
  crcp_back #(
    .ADDR_BITS(ADDR_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd_avail  (q_nonempty),
    .cmd        (q_cmd),
    .cmd_take   (q_pop),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_stall (desc_stall)
  );

  assign status          = desc.status;
  assign action          = desc.action;
  assign dst_addr        = desc.dst_addr;
  assign src_addr        = desc.src_addr;
  assign src_pitch_bytes = desc.src_pitch_bytes;
  assign row_pixels      = desc.row_pixels;
  assign copy_rows       = desc.copy_rows;
  assign fill_addr       = desc.fill_addr;
  assign fill_rows       = desc.fill_rows;
  assign fill_pixel      = desc.fill_pixel;

endmodule

// ----- sv/crcp_front.sv -----
module crcp_front #(
  parameter int MAX_DIM = 4096
) (
  input  crcp_pkg::cfg_t                    cfg,
  input  logic [2:0]                        mode,
  input  logic signed [15:0]                pos_x,
  input  logic signed [15:0]                pos_y,
  input  logic signed [15:0]                size_x,
  input  logic signed [15:0]                size_y,
  input  logic signed [15:0]                shift_rows,
  input  logic [crcp_pkg::COL_W-1:0]        color,
  input  logic [crcp_pkg::ADDR_W-1:0]       image_base,
  input  logic [crcp_pkg::STRD_W-1:0]       src_stride,
  output crcp_pkg::cmd_t                    cmd
);

  localparam int CW = crcp_pkg::CRD_W;
  localparam int DW = crcp_pkg::DIM_W;
  localparam logic [14:0] MAXD = 15'(MAX_DIM);

  typedef struct packed {
    logic          ok;
    logic [DW-1:0] lo;
    logic [DW-1:0] hi;
  } clip_t;

  // clip the closed span [a0,a1] to [0,lim)
  function automatic clip_t clip_span(input logic signed [CW-1:0] a0,
                                      input logic signed [CW-1:0] a1,
                                      input logic signed [CW-1:0] lim);
    clip_t                 r;
    logic signed [CW-1:0]  lo_w;
    logic signed [CW-1:0]  hi_w;
    r.ok = !((a1 < 0) || (a0 >= lim) || (a1 < a0));
    lo_w = (a0 < 0) ? '0 : a0;
    hi_w = (a1 >= lim) ? (lim - CW'(1)) : a1;
    r.lo = lo_w[DW-1:0];
    r.hi = hi_w[DW-1:0];
    return r;
  endfunction

  logic signed [CW-1:0] px, py, sx, sy, dys, nsx;
  logic signed [CW-1:0] x0, x1, y0, y1;
  logic signed [CW-1:0] lim_w, lim_h;
  logic [14:0]          w_eff, h_eff;
  logic                 rej;
  crcp_pkg::kind_t      kind;
  clip_t                cx, cy;

  // sign extend the origin and sizes
  assign px  = CW'(pos_x);
  assign py  = CW'(pos_y);
  assign sx  = CW'(size_x);
  assign sy  = CW'(size_y);
  assign dys = CW'(shift_rows);
  assign nsx = ~sx;

  // clip limits saturated to the largest screen dimension
  assign w_eff = ({2'b00, cfg.screen_width} > MAXD) ? MAXD : {2'b00, cfg.screen_width};
  assign h_eff = ({2'b00, cfg.screen_height} > MAXD) ? MAXD : {2'b00, cfg.screen_height};
  assign lim_w = CW'(signed'({1'b0, w_eff}));
  assign lim_h = CW'(signed'({1'b0, h_eff}));

  // span and legality per mode
  always_comb begin
    x0   = px;
    x1   = px;
    y0   = py;
    y1   = py;
    rej  = 1'b0;
    kind = crcp_pkg::KIND_FILL;
    case (crcp_pkg::mode_t'(mode))
      crcp_pkg::MODE_PIXEL: begin
      end
      crcp_pkg::MODE_HLINE: begin
        if (sx == 0) rej = 1'b1;
        if (sx < 0) begin
          x0 = px + nsx;
          x1 = px + nsx + nsx;
        end else begin
          x1 = px + sx - CW'(1);
        end
      end
      crcp_pkg::MODE_VLINE: begin
        if (sx == 0) rej = 1'b1;
        if (sx < 0) begin
          y0 = py + nsx;
          y1 = py + nsx + nsx;
        end else begin
          y1 = py + sx - CW'(1);
        end
      end
      crcp_pkg::MODE_RECT, crcp_pkg::MODE_SCROLL: begin
        if (sx <= 0 || sy <= 0) rej = 1'b1;
        if (crcp_pkg::mode_t'(mode) == crcp_pkg::MODE_SCROLL) begin
          kind = crcp_pkg::KIND_SCROLL;
          if (dys <= 0) rej = 1'b1;
        end
        x1 = px + sx - CW'(1);
        y1 = py + sy - CW'(1);
      end
      crcp_pkg::MODE_BLIT: begin
        kind = crcp_pkg::KIND_BLIT;
        if (sx <= 0 || sy <= 0 || image_base == '0 || src_stride == '0) rej = 1'b1;
        x1 = px + sx - CW'(1);
        y1 = py + sy - CW'(1);
      end
      default: begin
        rej = 1'b1;
      end
    endcase
  end

  assign cx = clip_span(x0, x1, lim_w);
  assign cy = clip_span(y0, y1, lim_h);

  // queue entry
  always_comb begin
    cmd.reject  = rej || !cx.ok || !cy.ok || !cfg.ready_cfg || (cfg.fb_base == '0);
    cmd.kind    = kind;
    cmd.x0      = cx.lo;
    cmd.y0      = cy.lo;
    cmd.width   = cx.hi - cx.lo + DW'(1);
    cmd.rows    = cy.hi - cy.lo + DW'(1);
    cmd.dy      = shift_rows;
    cmd.color   = color;
    cmd.sbase   = image_base;
    cmd.sstride = src_stride;
    cmd.ox      = (pos_x < 0) ? 16'(-px) : 16'd0;
    cmd.oy      = (pos_y < 0) ? 16'(-py) : 16'd0;
  end

endmodule

// ----- sv/crcp_queue.sv -----
module crcp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  crcp_pkg::cmd_t wdata,
  output logic           full,
  output logic           nonempty,
  output crcp_pkg::cmd_t rdata,
  input  logic           pop
);

  localparam int PW = $clog2(crcp_pkg::QDEPTH);

  crcp_pkg::cmd_t mem [crcp_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;
  logic           do_push;
  logic           do_pop;

  assign full     = (count == (PW+1)'(crcp_pkg::QDEPTH));
  assign nonempty = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign rdata    = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PW'(1);
      if (do_pop) rd_ptr <= rd_ptr + PW'(1);
      if (do_push && !do_pop) count <= count + (PW+1)'(1);
      else if (do_pop && !do_push) count <= count - (PW+1)'(1);
    end
  end

endmodule

// ----- sv/crcp_back.sv -----
module crcp_back #(
  parameter int ADDR_BITS = 48
) (
  input  logic            clk,
  input  logic            rst,
  input  crcp_pkg::cfg_t  cfg,
  input  logic            cmd_avail,
  input  crcp_pkg::cmd_t  cmd,
  output logic            cmd_take,
  output logic            desc_valid,
  output crcp_pkg::desc_t desc,
  input  logic            desc_stall
);

  localparam int AW = crcp_pkg::ADDR_W;
  localparam int DW = crcp_pkg::DIM_W;
  localparam int PW = crcp_pkg::PITCH_W;
  localparam int SW = crcp_pkg::STRD_W;
  localparam logic [AW-1:0] AMASK =
    (ADDR_BITS >= AW) ? {AW{1'b1}} : AW'((64'd1 << ADDR_BITS) - 64'd1);

  // fields that ride along with the address math
  typedef struct packed {
    logic                       reject;
    crcp_pkg::kind_t            kind;
    crcp_pkg::action_t          action;
    logic [DW-1:0]              x0;
    logic [DW-1:0]              width;
    logic [DW-1:0]              copy_rows;
    logic [DW-1:0]              fill_rows;
    logic [crcp_pkg::COL_W-1:0] color;
    logic [AW-1:0]              sbase;
    logic [SW-1:0]              sstride;
    logic [15:0]                ox;
  } side_t;

  logic          v_a, v_b;
  logic          rdy_a, rdy_b, rdy_c;
  side_t         a_side, b_side, side_next;
  logic [DW-1:0] a_ya, a_yb, a_yc;
  logic [15:0]   a_oy;
  logic [DW-1:0] yb_next, yc_next;
  logic          copy;
  logic [DW+PW-1:0] b_pa, b_pb, b_pc;
  logic [15+SW:0]   b_pbl;
  logic [AW-1:0] fa, fb, fc, sbl;
  crcp_pkg::desc_t desc_next;

  // stage handshakes
  assign rdy_c    = !desc_valid || !desc_stall;
  assign rdy_b    = !v_b || rdy_c;
  assign rdy_a    = !v_a || rdy_b;
  assign cmd_take = cmd_avail && rdy_a;

  // stage a: scroll split, row indexes and counts
  always_comb begin
    copy    = (cmd.kind == crcp_pkg::KIND_SCROLL) && ({3'b000, cmd.rows} > cmd.dy);
    yb_next = cmd.y0 + cmd.dy[DW-1:0];
    yc_next = copy ? (cmd.y0 + cmd.rows - cmd.dy[DW-1:0]) : cmd.y0;
    side_next.reject  = cmd.reject;
    side_next.kind    = cmd.kind;
    side_next.x0      = cmd.x0;
    side_next.width   = cmd.width;
    side_next.color   = cmd.color;
    side_next.sbase   = cmd.sbase;
    side_next.sstride = cmd.sstride;
    side_next.ox      = cmd.ox;
    if (cmd.kind == crcp_pkg::KIND_BLIT) begin
      side_next.action    = crcp_pkg::ACT_COPY;
      side_next.copy_rows = cmd.rows;
      side_next.fill_rows = '0;
    end else if (copy) begin
      side_next.action    = crcp_pkg::ACT_COPY_FILL;
      side_next.copy_rows = cmd.rows - cmd.dy[DW-1:0];
      side_next.fill_rows = cmd.dy[DW-1:0];
    end else begin
      side_next.action    = crcp_pkg::ACT_FILL;
      side_next.copy_rows = '0;
      side_next.fill_rows = cmd.rows;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_side <= side_next;
      a_ya   <= cmd.y0;
      a_yb   <= yb_next;
      a_yc   <= yc_next;
      a_oy   <= cmd.oy;
    end
  end

  // stage b: row offsets
  always_ff @(posedge clk) begin
    if (rdy_b) begin
      b_side <= a_side;
      b_pa   <= a_ya * cfg.row_pitch;
      b_pb   <= a_yb * cfg.row_pitch;
      b_pc   <= a_yc * cfg.row_pitch;
      b_pbl  <= a_oy * a_side.sstride;
    end
  end

  // stage c: byte addresses and descriptor assembly
  always_comb begin
    fa  = (cfg.fb_base + AW'({b_pa, 2'b00}) + AW'({b_side.x0, 2'b00})) & AMASK;
    fb  = (cfg.fb_base + AW'({b_pb, 2'b00}) + AW'({b_side.x0, 2'b00})) & AMASK;
    fc  = (cfg.fb_base + AW'({b_pc, 2'b00}) + AW'({b_side.x0, 2'b00})) & AMASK;
    sbl = (b_side.sbase + AW'(b_pbl) + AW'({b_side.ox, 2'b00})) & AMASK;
    desc_next = '0;
    if (b_side.reject) begin
      desc_next.status = 1'b1;
    end else begin
      desc_next.action     = b_side.action;
      desc_next.dst_addr   = fa;
      desc_next.row_pixels = b_side.width;
      desc_next.copy_rows  = b_side.copy_rows;
      desc_next.fill_rows  = b_side.fill_rows;
      case (b_side.action)
        crcp_pkg::ACT_COPY: begin
          desc_next.src_addr        = sbl;
          desc_next.src_pitch_bytes = b_side.sstride;
        end
        crcp_pkg::ACT_COPY_FILL: begin
          desc_next.src_addr        = fb;
          desc_next.src_pitch_bytes = SW'({cfg.row_pitch, 2'b00});
          desc_next.fill_addr       = fc;
          desc_next.fill_pixel      = b_side.color;
        end
        default: begin
          desc_next.fill_addr  = fa;
          desc_next.fill_pixel = b_side.color;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c) desc <= desc_next;
  end

  // stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a        <= 1'b0;
      v_b        <= 1'b0;
      desc_valid <= 1'b0;
    end else begin
      if (rdy_a) v_a <= cmd_avail;
      if (rdy_b) v_b <= v_a;
      if (rdy_c) desc_valid <= v_b;
    end
  end

endmodule
